### src/dngr_pkg.sv
// Package for the decimal glyph renderer: shared types, widths and the 3x5 font ROM.
// Depends on nothing; every other file of the block imports it.
package dngr_pkg;

    localparam int unsigned ORIGIN_W    = 4;
    localparam int unsigned VALUE_W     = 14;
    localparam int unsigned PIXEL_W     = 5;
    localparam int unsigned DIGIT_CNT   = 4;
    localparam int unsigned DIGIT_PITCH = 4;
    localparam int unsigned GLYPH_ROWS  = 5;
    localparam int unsigned GLYPH_COLS  = 3;
    localparam int unsigned BCD_W       = 4 * DIGIT_CNT;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 16;

    localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(9999);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic scan_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_last;
        logic scan_lit;
        logic scan_final;
        logic out_free;
    } t_status;

    // One row of a glyph; bit (GLYPH_COLS-1-c) set means column c is lit.
    function automatic logic [GLYPH_COLS-1:0] font_row(input logic [3:0] digit,
                                                        input logic [2:0] row);
        logic [GLYPH_COLS*GLYPH_ROWS-1:0] glyph;
        case (digit)
            4'd0:    glyph = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            4'd1:    glyph = {3'd1, 3'd1, 3'd1, 3'd1, 3'd1};
            4'd2:    glyph = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
            4'd3:    glyph = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
            4'd4:    glyph = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
            4'd5:    glyph = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            4'd6:    glyph = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
            4'd7:    glyph = {3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
            4'd8:    glyph = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            4'd9:    glyph = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
            default: glyph = '0;
        endcase
        // Row 0 is held in the top bits of the concatenation.
        case (row)
            3'd0:    font_row = glyph[14:12];
            3'd1:    font_row = glyph[11:9];
            3'd2:    font_row = glyph[8:6];
            3'd3:    font_row = glyph[5:3];
            3'd4:    font_row = glyph[2:0];
            default: font_row = '0;
        endcase
    endfunction

endpackage

### src/dngr_ctrl.sv
// Controller state machine for the decimal glyph renderer.
// Depends on dngr_pkg; drives commands to dngr_dpath and reads its status.
module dngr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dngr_pkg::t_status i_status,
    output dngr_pkg::t_cmd    o_cmd
);
    import dngr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_scan_go;

    // A cell is passed over at once when unlit, otherwise only when the output register is free.
    assign w_scan_go = !i_status.scan_lit || i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (i_status.conv_last) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_scan_go && i_status.scan_final) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.conv_step = 1'b0;
        o_cmd.scan_step = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CONV: begin
                o_cmd.conv_step = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_step = w_scan_go;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### src/dngr_dpath.sv
// Datapath for the decimal glyph renderer: binary to BCD shifter, glyph scan and output register.
// Depends on dngr_pkg; commanded by dngr_ctrl.
module dngr_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dngr_pkg::t_cmd                i_cmd,
    output dngr_pkg::t_status             o_status,
    input  logic [dngr_pkg::ORIGIN_W-1:0] i_origin_x,
    input  logic [dngr_pkg::ORIGIN_W-1:0] i_origin_y,
    input  logic [dngr_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dngr_pkg::PIXEL_W-1:0]  o_pixel_x,
    output logic [dngr_pkg::PIXEL_W-1:0]  o_pixel_y,
    output logic                          o_last_pixel
);
    import dngr_pkg::*;

    logic [ORIGIN_W-1:0] r_org_x;
    logic [ORIGIN_W-1:0] r_org_y;
    logic [VALUE_W-1:0]  r_bin;
    logic [BCD_W-1:0]    r_bcd;
    logic [BCD_W-1:0]    w_bcd_adj;
    logic [3:0]          r_bit_cnt;
    logic [1:0]          r_digit;
    logic [2:0]          r_row;
    logic [1:0]          r_col;
    logic [3:0]          w_digit_val;
    logic [GLYPH_COLS-1:0] w_row_bits;
    logic                w_lit;
    logic                w_final;
    logic                w_emit;
    logic                r_out_valid;
    logic [PIXEL_W-1:0]  r_pixel_x;
    logic [PIXEL_W-1:0]  r_pixel_y;
    logic                r_last;

    // Double dabble: every BCD nibble of five or more gets three added before the shift.
    always_comb begin
        for (int i = 0; i < DIGIT_CNT; i++) begin
            w_bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                             : r_bcd[4*i +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_org_x   <= i_origin_x;
            r_org_y   <= i_origin_y;
            r_bin     <= (i_value > VALUE_MAX) ? VALUE_MAX : i_value;
            r_bcd     <= '0;
            r_bit_cnt <= '0;
        end else if (i_cmd.conv_step) begin
            {r_bcd, r_bin} <= {w_bcd_adj[BCD_W-2:0], r_bin, 1'b0};
            r_bit_cnt      <= r_bit_cnt + 4'd1;
        end
    end

    // Thousands digit sits in the top nibble.
    always_comb begin
        case (r_digit)
            2'd0:    w_digit_val = r_bcd[15:12];
            2'd1:    w_digit_val = r_bcd[11:8];
            2'd2:    w_digit_val = r_bcd[7:4];
            2'd3:    w_digit_val = r_bcd[3:0];
            default: w_digit_val = '0;
        endcase
    end

    assign w_row_bits = font_row(w_digit_val, r_row);
    assign w_lit      = w_row_bits[2'(GLYPH_COLS-1) - r_col];
    // Every glyph lights its bottom-right pixel, so the final cell is always the last pixel.
    assign w_final    = (r_digit == 2'(DIGIT_CNT-1)) && (r_row == 3'(GLYPH_ROWS-1)) &&
                        (r_col == 2'(GLYPH_COLS-1));
    assign w_emit     = i_cmd.scan_step && w_lit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_digit <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else if (i_cmd.scan_step) begin
            if (r_col == 2'(GLYPH_COLS-1)) begin
                r_col <= '0;
                if (r_row == 3'(GLYPH_ROWS-1)) begin
                    r_row   <= '0;
                    r_digit <= r_digit + 2'd1;
                end else begin
                    r_row <= r_row + 3'd1;
                end
            end else begin
                r_col <= r_col + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_pixel_x <= PIXEL_W'(r_org_x) + PIXEL_W'(DIGIT_PITCH * r_digit) + PIXEL_W'(r_col);
            r_pixel_y <= PIXEL_W'(r_org_y) + PIXEL_W'(r_row);
            r_last    <= w_final;
        end
    end

    assign o_status.conv_last  = (r_bit_cnt == 4'(VALUE_W-1));
    assign o_status.scan_lit   = w_lit;
    assign o_status.scan_final = w_final;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_pixel_x;
    assign o_pixel_y    = r_pixel_y;
    assign o_last_pixel = r_last;

endmodule

### src/decimal_number_glyph_renderer_core.sv
// Decimal glyph renderer, top level. The first pixel beat is presented after the 14-step binary
// to BCD shifter and the glyph scan, which passes over unlit cells one per cycle, so a thousands
// digit of one, whose top row lights only its right column, delays the first beat.
// Numbers are taken one at a time: each passes the accepting cycle, the 14-step BCD shifter and
// a scan that, without back-pressure, spends one cycle on each of the 60 glyph cells, lit or not.
// Reset (synchronous, active low) clears the controller state and the output valid flag.
// Depends on dngr_pkg, dngr_ctrl and dngr_dpath.
module decimal_number_glyph_renderer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // From bit 0: origin_x[3:0], origin_y[7:4], value[21:8], zero padding[23:22].
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // From bit 0: pixel_x[4:0], pixel_y[9:5], zero padding[15:10].
    output logic [15:0] m_axis_tdata,
    // Set on the final lit pixel of a number.
    output logic        m_axis_tlast
);
    import dngr_pkg::*;

    t_cmd               w_cmd;
    t_status            w_status;
    logic [PIXEL_W-1:0] w_pixel_x;
    logic [PIXEL_W-1:0] w_pixel_y;

    // The controller takes a number only when idle. It goes back to idle as soon as the final
    // pixel is in the output register, so the next number can start its BCD shift while that
    // beat still waits to be taken.
    dngr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath saturates the value at 9999, converts it to four BCD digits and walks every
    // glyph cell in digit, row and column order, loading lit cells into the output register.
    dngr_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_origin_x   (s_axis_tdata[3:0]),
        .i_origin_y   (s_axis_tdata[7:4]),
        .i_value      (s_axis_tdata[21:8]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_pixel_x    (w_pixel_x),
        .o_pixel_y    (w_pixel_y),
        .o_last_pixel (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - 2*PIXEL_W){1'b0}}, w_pixel_y, w_pixel_x};

endmodule
